[hw/rtl/eulr_pkg.sv]
package eulr_pkg;

  localparam int COEF_FRAC_BITS_DEF = 16;
  localparam int COMPONENT_BITS_DEF = 16;

  // fixed-point format of the coefficient sequencer
  localparam int WORK_BITS = 30;
  localparam int ANG_FRAC  = 14;
  localparam int RW        = 34;
  localparam int MW        = 33;
  localparam int PW        = 2 * MW;
  localparam int RECIP_SH  = 32;
  localparam int NUM_ANG   = 3;
  localparam int NUM_COEF  = 9;
  localparam int NUM_RF    = 14;

  localparam logic signed [MW-1:0] PI_Q29 = 33'sd1686629713;

  // program layout: phases 0..2 run sin/cos of one angle, phase 3 the matrix
  localparam logic [1:0] PH_MAT   = 2'd3;
  localparam logic [4:0] ANG_LAST = 5'd20;
  localparam logic [4:0] MAT_LAST = 5'd22;

  typedef logic [1:0] reg_addr_t;
  localparam reg_addr_t REG_ANG_X = 2'd0;
  localparam reg_addr_t REG_ANG_Y = 2'd1;
  localparam reg_addr_t REG_ANG_Z = 2'd2;

  typedef enum logic [1:0] {SQ_IDLE, SQ_RD, SQ_MU, SQ_WB} seq_state_t;

  typedef enum logic [2:0] {OP_ANG, OP_MUL, OP_DIV, OP_QSIN, OP_QCOS, OP_COEF} op_kind_t;

  typedef enum logic [3:0] {
    R_X, R_X2, R_T, R_S, R_C, R_SX, R_CX, R_SY, R_CY, R_SZ, R_CZ, R_A, R_B, R_M
  } rf_idx_t;

  typedef struct packed {
    op_kind_t    kind;
    rf_idx_t     a;
    rf_idx_t     b;
    rf_idx_t     dst;
    logic [3:0]  cidx;
    logic [6:0]  div;
    logic [31:0] recip;
    logic        neg;
    logic        acc;
  } uop_t;

  function automatic uop_t mk(input op_kind_t k, input rf_idx_t a, input rf_idx_t b,
                              input rf_idx_t d);
    uop_t u;
    u.kind  = k;
    u.a     = a;
    u.b     = b;
    u.dst   = d;
    u.cidx  = 4'd0;
    u.div   = 7'd1;
    u.recip = 32'd0;
    u.neg   = 1'b0;
    u.acc   = 1'b0;
    return u;
  endfunction

  // dst = 1.0 - floor(src / div), recip = floor(2^32 / div)
  function automatic uop_t dv(input rf_idx_t s, input rf_idx_t d, input logic [6:0] div,
                              input logic [31:0] recip);
    uop_t u;
    u       = mk(OP_DIV, s, s, d);
    u.div   = div;
    u.recip = recip;
    return u;
  endfunction

  function automatic uop_t mm(input rf_idx_t a, input rf_idx_t b, input logic neg,
                              input logic acc);
    uop_t u;
    u     = mk(OP_MUL, a, b, R_M);
    u.neg = neg;
    u.acc = acc;
    return u;
  endfunction

  function automatic uop_t cf(input rf_idx_t s, input logic [3:0] idx, input logic neg);
    uop_t u;
    u      = mk(OP_COEF, s, s, R_M);
    u.cidx = idx;
    u.neg  = neg;
    return u;
  endfunction

  function automatic uop_t seq_uop(input logic [1:0] ph, input logic [4:0] st);
    uop_t    u;
    rf_idx_t sd;
    rf_idx_t cd;
    u = mk(OP_MUL, R_X, R_X, R_X);
    unique case (ph)
      2'd0: begin sd = R_SX; cd = R_CX; end
      2'd1: begin sd = R_SY; cd = R_CY; end
      default: begin sd = R_SZ; cd = R_CZ; end
    endcase
    if (ph != PH_MAT) begin
      unique case (st)
        5'd0:  u = mk(OP_ANG, R_X, R_X, R_X);
        5'd1:  u = mk(OP_MUL, R_X, R_X, R_X2);
        5'd2:  u = dv(R_X2, R_T, 7'd72, 32'd59652323);
        5'd3:  u = mk(OP_MUL, R_X2, R_T, R_T);
        5'd4:  u = dv(R_T, R_T, 7'd42, 32'd102261126);
        5'd5:  u = mk(OP_MUL, R_X2, R_T, R_T);
        5'd6:  u = dv(R_T, R_T, 7'd20, 32'd214748364);
        5'd7:  u = mk(OP_MUL, R_X2, R_T, R_T);
        5'd8:  u = dv(R_T, R_T, 7'd6, 32'd715827882);
        5'd9:  u = mk(OP_MUL, R_X, R_T, R_S);
        5'd10: u = dv(R_X2, R_T, 7'd90, 32'd47721858);
        5'd11: u = mk(OP_MUL, R_X2, R_T, R_T);
        5'd12: u = dv(R_T, R_T, 7'd56, 32'd76695844);
        5'd13: u = mk(OP_MUL, R_X2, R_T, R_T);
        5'd14: u = dv(R_T, R_T, 7'd30, 32'd143165576);
        5'd15: u = mk(OP_MUL, R_X2, R_T, R_T);
        5'd16: u = dv(R_T, R_T, 7'd12, 32'd357913941);
        5'd17: u = mk(OP_MUL, R_X2, R_T, R_T);
        5'd18: u = dv(R_T, R_C, 7'd2, 32'd2147483648);
        5'd19: u = mk(OP_QSIN, R_S, R_C, sd);
        5'd20: u = mk(OP_QCOS, R_S, R_C, cd);
        default: u = mk(OP_MUL, R_X, R_X, R_X);
      endcase
    end else begin
      unique case (st)
        5'd0:  u = mk(OP_MUL, R_CZ, R_SY, R_A);
        5'd1:  u = mk(OP_MUL, R_SZ, R_SY, R_B);
        5'd2:  u = mm(R_CZ, R_CY, 1'b0, 1'b0);
        5'd3:  u = cf(R_M, 4'd0, 1'b0);
        5'd4:  u = mm(R_SZ, R_CX, 1'b1, 1'b0);
        5'd5:  u = mm(R_A, R_SX, 1'b0, 1'b1);
        5'd6:  u = cf(R_M, 4'd1, 1'b0);
        5'd7:  u = mm(R_SZ, R_SX, 1'b0, 1'b0);
        5'd8:  u = mm(R_A, R_CX, 1'b0, 1'b1);
        5'd9:  u = cf(R_M, 4'd2, 1'b0);
        5'd10: u = mm(R_SZ, R_CY, 1'b0, 1'b0);
        5'd11: u = cf(R_M, 4'd3, 1'b0);
        5'd12: u = mm(R_CZ, R_CX, 1'b0, 1'b0);
        5'd13: u = mm(R_B, R_SX, 1'b0, 1'b1);
        5'd14: u = cf(R_M, 4'd4, 1'b0);
        5'd15: u = mm(R_CZ, R_SX, 1'b1, 1'b0);
        5'd16: u = mm(R_B, R_CX, 1'b0, 1'b1);
        5'd17: u = cf(R_M, 4'd5, 1'b0);
        5'd18: u = cf(R_SY, 4'd6, 1'b1);
        5'd19: u = mm(R_CY, R_SX, 1'b0, 1'b0);
        5'd20: u = cf(R_M, 4'd7, 1'b0);
        5'd21: u = mm(R_CY, R_CX, 1'b0, 1'b0);
        5'd22: u = cf(R_M, 4'd8, 1'b0);
        default: u = mk(OP_MUL, R_X, R_X, R_X);
      endcase
    end
    return u;
  endfunction

endpackage

[hw/rtl/eulr_seq.sv]
module eulr_seq import eulr_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic [NUM_ANG-1:0][15:0]                   ang,
  output logic                                       busy,
  output logic [NUM_COEF*(COEF_FRAC_BITS+2)-1:0]     coef
);

  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int SH = WORK_BITS - COEF_FRAC_BITS;
  localparam logic signed [RW-1:0] C_HALF = RW'((64'sd1 << SH) >> 1);
  localparam logic signed [RW-1:0] C_LIM  = RW'(64'sd1 << COEF_FRAC_BITS);
  localparam logic signed [RW-1:0] ONE    = RW'(64'sd1 << WORK_BITS);
  localparam logic signed [PW-1:0] HALF_W = PW'(64'sd1 << (WORK_BITS - 1));
  localparam logic signed [PW-1:0] HALF_A = PW'(64'sd1 << (ANG_FRAC - 1));

  seq_state_t st_r, st_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [4:0] stp_r, stp_nxt;

  logic signed [RW-1:0] rf [NUM_RF];
  logic signed [RW-1:0] ra_r, rb_r, acc_r;
  logic signed [PW-1:0] p_r;
  logic signed [CW-1:0] coef_r [NUM_COEF];

  uop_t                 uop;
  logic [15:0]          cur_ang, ang_off;
  logic [1:0]           quad;
  logic signed [13:0]   red;
  logic signed [MW-1:0] opa, opb;
  logic signed [PW-1:0] pw_rnd, pa_rnd;
  logic signed [RW-1:0] pm, mres, q0, rem, dq, dres, dvs, cv, cr, res;
  logic signed [RW-1:0] qs, qc;

  assign uop  = seq_uop(ph_r, stp_r);
  assign busy = (st_r != SQ_IDLE);

  always_comb begin
    unique case (ph_r)
      2'd0: cur_ang = ang[0];
      2'd1: cur_ang = ang[1];
      2'd2: cur_ang = ang[2];
      default: cur_ang = '0;
    endcase
  end

  // octant-centered reduction: quadrant plus residual in -pi/4..pi/4
  assign ang_off = cur_ang + 16'd8192;
  assign quad    = ang_off[15:14];
  assign red     = {~ang_off[13], ang_off[12:0]};

  always_comb begin
    st_nxt  = st_r;
    ph_nxt  = ph_r;
    stp_nxt = stp_r;
    if (start) begin
      st_nxt  = SQ_RD;
      ph_nxt  = '0;
      stp_nxt = '0;
    end else begin
      unique case (st_r)
        SQ_IDLE: st_nxt = SQ_IDLE;
        SQ_RD:   st_nxt = SQ_MU;
        SQ_MU:   st_nxt = SQ_WB;
        SQ_WB: begin
          st_nxt = SQ_RD;
          if (ph_r != PH_MAT) begin
            if (stp_r == ANG_LAST) begin
              ph_nxt  = ph_r + 2'd1;
              stp_nxt = '0;
            end else begin
              stp_nxt = stp_r + 5'd1;
            end
          end else if (stp_r == MAT_LAST) begin
            st_nxt = SQ_IDLE;
          end else begin
            stp_nxt = stp_r + 5'd1;
          end
        end
        default: st_nxt = SQ_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= SQ_IDLE;
      ph_r  <= '0;
      stp_r <= '0;
    end else begin
      st_r  <= st_nxt;
      ph_r  <= ph_nxt;
      stp_r <= stp_nxt;
    end
  end

  always_comb begin
    unique case (uop.kind)
      OP_ANG: begin
        opa = MW'(red);
        opb = PI_Q29;
      end
      OP_DIV: begin
        opa = ra_r[MW-1:0];
        opb = $signed({1'b0, uop.recip});
      end
      default: begin
        opa = ra_r[MW-1:0];
        opb = rb_r[MW-1:0];
      end
    endcase
  end

  always_comb begin
    pw_rnd = (p_r + HALF_W) >>> WORK_BITS;
    pa_rnd = (p_r + HALF_A) >>> ANG_FRAC;
    pm     = RW'(pw_rnd);
    mres   = (uop.neg ? -pm : pm) + (uop.acc ? acc_r : '0);

    // truncating divide: reciprocal estimate is low by at most one
    q0   = $signed({2'b00, p_r[RECIP_SH +: 32]});
    dvs  = $signed({{(RW-7){1'b0}}, uop.div});
    rem  = ra_r - RW'(q0 * dvs);
    dq   = (rem >= dvs) ? q0 + RW'(1) : q0;
    dres = ONE - dq;

    unique case (quad)
      2'd0: begin qs = ra_r;  qc = rb_r;  end
      2'd1: begin qs = rb_r;  qc = -ra_r; end
      2'd2: begin qs = -ra_r; qc = -rb_r; end
      default: begin qs = -rb_r; qc = ra_r; end
    endcase

    cv = uop.neg ? -ra_r : ra_r;
    cr = (cv + C_HALF) >>> SH;
    if (cr > C_LIM) begin
      cr = C_LIM;
    end else if (cr < -C_LIM) begin
      cr = -C_LIM;
    end

    unique case (uop.kind)
      OP_ANG:  res = RW'(pa_rnd);
      OP_MUL:  res = mres;
      OP_DIV:  res = dres;
      OP_QSIN: res = qs;
      OP_QCOS: res = qc;
      default: res = cr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == SQ_RD) begin
      ra_r <= rf[uop.a];
      rb_r <= rf[uop.b];
    end
    if (st_r == SQ_WB && uop.kind != OP_COEF) begin
      rf[uop.dst] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == SQ_MU) begin
      p_r <= opa * opb;
    end
    if (st_r == SQ_WB && uop.kind == OP_MUL) begin
      acc_r <= mres;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= (i % 4 == 0) ? CW'(64'sd1 << COEF_FRAC_BITS) : '0;
      end
    end else if (st_r == SQ_WB && uop.kind == OP_COEF) begin
      coef_r[uop.cidx] <= CW'(cr);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_COEF; i++) begin
      coef[i*CW +: CW] = coef_r[i];
    end
  end

endmodule

[hw/rtl/eulr_lane.sv]
module eulr_lane import eulr_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 ld,
  input  logic [3*(COEF_FRAC_BITS+2)-1:0]      coef_row,
  input  logic [2:0][COMPONENT_BITS-1:0]       vec,
  output logic signed [COMPONENT_BITS:0]       res
);

  localparam int CW  = COEF_FRAC_BITS + 2;
  localparam int PRW = CW + COMPONENT_BITS;
  localparam int SW  = PRW + 2;
  localparam logic signed [SW-1:0] HALF = SW'(64'sd1 << (COEF_FRAC_BITS - 1));
  localparam logic signed [SW-1:0] HI   = SW'((64'sd1 << COMPONENT_BITS) - 1);
  localparam logic signed [SW-1:0] LO   = -SW'(64'sd1 << COMPONENT_BITS);

  logic signed [PRW-1:0] prod_r [3];
  logic signed [SW-1:0]  sum, rnd;

  always_ff @(posedge clk) begin
    if (ld) begin
      for (int j = 0; j < 3; j++) begin
        prod_r[j] <= $signed(coef_row[j*CW +: CW]) * $signed(vec[j]);
      end
    end
  end

  always_comb begin
    sum = SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2]);
    rnd = (sum + HALF) >>> COEF_FRAC_BITS;
    if (rnd > HI) begin
      rnd = HI;
    end else if (rnd < LO) begin
      rnd = LO;
    end
    res = rnd[COMPONENT_BITS:0];
  end

endmodule

[hw/rtl/euler_xyz_vector_rotation.sv]
// channel   ports                          dir  moves
// config    psel/penable/pwrite/paddr/...  in   angle registers x, y, z at 0x0/0x4/0x8
// input     in_valid/in_stall/in_vec_*     in   one vector item per cycle while in_stall is low
// output    out_valid/out_stall/out_rot_*  out  one rotated vector per input item
//
// one item per cycle sustained while in_stall is low; registered in lane products, then output register
// an angle write starts the coefficient sequencer: 86 steps (read, multiply, write back) on a
//   shared 33x33 multiplier, during which the input is stalled
// reset loads the identity matrix and zero angles; the block is ready right after reset
// a stalled output keeps one more item in the product stage before the input stalls
module euler_xyz_vector_rotation import eulr_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [3:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [COMPONENT_BITS-1:0] in_vec_x,
  input  logic signed [COMPONENT_BITS-1:0] in_vec_y,
  input  logic signed [COMPONENT_BITS-1:0] in_vec_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [COMPONENT_BITS:0]   out_rot_x,
  output logic signed [COMPONENT_BITS:0]   out_rot_y,
  output logic signed [COMPONENT_BITS:0]   out_rot_z
);

  localparam int CW = COEF_FRAC_BITS + 2;

  logic [NUM_ANG-1:0][15:0]       ang_r;
  logic                           wr, start, busy;
  reg_addr_t                      ridx;
  logic [NUM_COEF*CW-1:0]         coef;
  logic [2:0][COMPONENT_BITS-1:0] vec;
  logic signed [COMPONENT_BITS:0] lane_res [3];
  logic signed [COMPONENT_BITS:0] rot_r [3];
  logic                           s1_v_r, s1_v_nxt, out_v_r, out_v_nxt;
  logic                           s1_adv, s2_adv, in_acc;

  assign pready = 1'b1;
  assign ridx   = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign start  = wr && (ridx == REG_ANG_X || ridx == REG_ANG_Y || ridx == REG_ANG_Z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r <= '0;
    end else if (start) begin
      ang_r[ridx] <= pwdata[15:0];
    end
  end

  always_comb begin
    unique case (ridx)
      REG_ANG_X: prdata = {{16{ang_r[0][15]}}, ang_r[0]};
      REG_ANG_Y: prdata = {{16{ang_r[1][15]}}, ang_r[1]};
      REG_ANG_Z: prdata = {{16{ang_r[2][15]}}, ang_r[2]};
      default:   prdata = '0;
    endcase
  end

  eulr_seq #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .ang   (ang_r),
    .busy  (busy),
    .coef  (coef)
  );

  assign s2_adv   = !out_v_r || !out_stall;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_stall = busy || !s1_adv;
  assign in_acc   = in_valid && !in_stall;
  assign vec      = {in_vec_z, in_vec_y, in_vec_x};

  for (genvar i = 0; i < 3; i++) begin : g_lane
    eulr_lane #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .COMPONENT_BITS (COMPONENT_BITS)
    ) u_lane (
      .clk      (clk),
      .ld       (in_acc),
      .coef_row (coef[i*3*CW +: 3*CW]),
      .vec      (vec),
      .res      (lane_res[i])
    );
  end

  always_comb begin
    s1_v_nxt  = s1_adv ? in_acc : s1_v_r;
    out_v_nxt = s2_adv ? s1_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // merge the three lane rows into the output register
  always_ff @(posedge clk) begin
    if (s2_adv && s1_v_r) begin
      for (int i = 0; i < 3; i++) begin
        rot_r[i] <= lane_res[i];
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_rot_x = rot_r[0];
  assign out_rot_y = rot_r[1];
  assign out_rot_z = rot_r[2];

endmodule

[hw/rtl/eulr_chk.sv]
module eulr_chk import eulr_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [3:0]                       paddr,
  input logic                             pready,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [COMPONENT_BITS:0]   out_rot_x,
  input logic signed [COMPONENT_BITS:0]   out_rot_y,
  input logic signed [COMPONENT_BITS:0]   out_rot_z
);

  a_ready_high: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

  a_rst_clears: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
    else $error("output valid after reset");

  // a register write must hold off input items while coefficients are rebuilt
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite &&
     (paddr[3:2] == REG_ANG_X || paddr[3:2] == REG_ANG_Y || paddr[3:2] == REG_ANG_Z))
    |=> in_stall)
    else $error("input taken during coefficient update");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rot_x) && $stable(out_rot_y)
      && $stable(out_rot_z))
    else $error("stalled output item changed");

endmodule

bind euler_xyz_vector_rotation eulr_chk #(.COMPONENT_BITS(COMPONENT_BITS)) u_chk (.*);
